// ----- src/bvhq_pkg.sv -----
package bvhq_pkg;

	localparam int NODES_DEF = 64;
	localparam int MAX_HITS  = 64;
	localparam int T_W       = 19;
	localparam int Q_W       = 18;

	localparam logic signed [T_W-1:0] T_ONE = 19'sd65536;
	localparam logic signed [T_W-1:0] T_MAX = 19'sd131071;
	localparam logic signed [T_W-1:0] T_MIN = -19'sd131072;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_RECT  = 2'd1;
	localparam logic [1:0] MODE_SEG   = 2'd2;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_z;
		logic               leaf;
		logic [6:0]         skip;
	} node_t;

endpackage

// ----- src/bvhq_ram.sv -----
module bvhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- src/bvh_escape_index_overlap_query_core.sv -----
// Node write and unused mode: one result, issued from S_FIN once the output register is free.
// Query: walks nodes one at a time through a single node memory read port.
// Rectangle test visits each node through FETCH, EVAL and DECIDE; the segment test
// adds up to two divisions per axis on one shared 18-step restoring divider.
// One request at a time; hits leave through a one-entry output register.
// arst_n clears control state and node_count; node memory is not cleared.
module bvh_escape_index_overlap_query_core #(
	parameter int NODES = bvhq_pkg::NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [5:0]         node_index,
	input  logic signed [31:0] coord_x0,
	input  logic signed [31:0] coord_z0,
	input  logic signed [31:0] coord_x1,
	input  logic signed [31:0] coord_z1,
	input  logic               is_leaf,
	input  logic [6:0]         skip_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         leaf_index,
	output logic               found,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data
);

	localparam int AW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 128);
	localparam int TW = bvhq_pkg::T_W;
	localparam int QW = bvhq_pkg::Q_W;

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_EVAL, S_AXIS, S_DIV, S_TDONE, S_DECIDE, S_FIN
	} state_t;

	state_t                state_q;
	logic [6:0]            node_count_q;
	logic [1:0]            mode_q;
	logic signed [31:0]    px_q, pz_q, qx_q, qz_q;
	logic [CW-1:0]         i_q;
	logic [6:0]            hits_q;
	logic                  pend_valid_q;
	logic [5:0]            pend_idx_q;
	logic                  ov_q;
	logic                  axis_q;
	logic                  bsel_q;
	logic signed [TW-1:0]  tmin_q, tmax_q, t1_q;
	logic [50:0]           rem_q;
	logic [49:0]           dsh_q;
	logic [QW-1:0]         quo_q;
	logic                  ovf_q;
	logic                  neg_q;
	logic [4:0]            cnt_q;
	logic                  out_valid_q;
	logic [5:0]            out_idx_q;
	logic                  out_found_q;
	logic                  out_last_q;

	bvhq_pkg::node_t       wr_node;
	bvhq_pkg::node_t       node;
	logic [$bits(bvhq_pkg::node_t)-1:0] rd_raw;
	logic                  wr_en;

	assign in_ready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign leaf_index = out_idx_q;
	assign found      = out_found_q;
	assign last       = out_last_q;

	// node store
	assign wr_node.min_x = coord_x0;
	assign wr_node.min_z = coord_z0;
	assign wr_node.max_x = coord_x1;
	assign wr_node.max_z = coord_z1;
	assign wr_node.leaf  = is_leaf;
	assign wr_node.skip  = skip_count;
	assign wr_en = in_valid && in_ready && (mode == bvhq_pkg::MODE_WRITE)
		&& (CW'(node_index) < CW'(NODES));

	bvhq_ram #(
		.WIDTH($bits(bvhq_pkg::node_t)),
		.DEPTH(NODES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(node_index)),
		.wr_data(wr_node),
		.rd_addr(i_q[AW-1:0]),
		.rd_data(rd_raw)
	);
	assign node = rd_raw;

	// walk bound
	logic [CW-1:0] limit;
	assign limit = (CW'(node_count_q) > CW'(NODES)) ? CW'(NODES) : CW'(node_count_q);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// rectangle overlap
	logic rect_ov;
	assign rect_ov = !(px_q > node.max_x || qx_q < node.min_x ||
		pz_q > node.max_z || qz_q < node.min_z);

	// current axis operands
	logic signed [31:0] cur_p, cur_q, cur_lo, cur_hi, cur_bound;
	assign cur_p  = axis_q ? pz_q : px_q;
	assign cur_q  = axis_q ? qz_q : qx_q;
	assign cur_lo = axis_q ? node.min_z : node.min_x;
	assign cur_hi = axis_q ? node.max_z : node.max_x;
	assign cur_bound = (state_q == S_TDONE) ? cur_hi : cur_lo;

	// divider setup
	logic signed [32:0] d_s, n_s;
	logic [32:0]        d_mag, n_mag;
	logic [48:0]        n_sh;
	logic               setup_ovf;
	assign d_s   = 33'(cur_q) - 33'(cur_p);
	assign n_s   = 33'(cur_bound) - 33'(cur_p);
	assign d_mag = d_s[32] ? 33'(-d_s) : 33'(d_s);
	assign n_mag = n_s[32] ? 33'(-n_s) : 33'(n_s);
	assign n_sh  = {n_mag, 16'd0};
	assign setup_ovf = {2'b00, n_sh} >= {d_mag, 18'd0};

	// divider step
	logic        div_ge;
	logic [50:0] div_diff;
	assign div_ge   = rem_q >= {1'b0, dsh_q};
	assign div_diff = rem_q - {1'b0, dsh_q};

	// saturated t from finished quotient
	logic signed [TW-1:0] t_sat;
	always_comb begin
		if (!neg_q) begin
			t_sat = (ovf_q || quo_q > 18'd131071) ? bvhq_pkg::T_MAX : TW'($signed({1'b0, quo_q}));
		end else begin
			t_sat = (ovf_q || quo_q > 18'd131072) ? bvhq_pkg::T_MIN
				: TW'(-$signed({1'b0, quo_q}));
		end
	end

	// slab interval update
	logic signed [TW-1:0] t_lo, t_hi, nmin, nmax;
	assign t_lo = (t1_q > t_sat) ? t_sat : t1_q;
	assign t_hi = (t1_q > t_sat) ? t1_q : t_sat;
	assign nmin = (t_lo > tmin_q) ? t_lo : tmin_q;
	assign nmax = (t_hi < tmax_q) ? t_hi : tmax_q;

	// walk advance
	logic          hit;
	logic [6:0]    step;
	logic [CW-1:0] i_next;
	assign hit    = node.leaf && ov_q;
	assign step   = (ov_q || node.leaf || node.skip == 7'd0) ? 7'd1 : node.skip;
	assign i_next = i_q + CW'(step);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= 7'd0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			i_q          <= '0;
			hits_q       <= 7'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q       <= mode;
						px_q         <= coord_x0;
						pz_q         <= coord_z0;
						qx_q         <= coord_x1;
						qz_q         <= coord_z1;
						i_q          <= '0;
						hits_q       <= 7'd0;
						pend_valid_q <= 1'b0;
						if ((mode == bvhq_pkg::MODE_RECT || mode == bvhq_pkg::MODE_SEG)
							&& limit != '0) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (mode_q == bvhq_pkg::MODE_RECT) begin
						ov_q    <= rect_ov;
						state_q <= S_DECIDE;
					end else begin
						axis_q  <= 1'b0;
						tmin_q  <= '0;
						tmax_q  <= bvhq_pkg::T_ONE;
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					if (d_s == '0) begin
						if (cur_p < cur_lo || cur_p > cur_hi) begin
							ov_q    <= 1'b0;
							state_q <= S_DECIDE;
						end else if (axis_q) begin
							ov_q    <= 1'b1;
							state_q <= S_DECIDE;
						end else begin
							axis_q <= 1'b1;
						end
					end else begin
						rem_q   <= {2'b00, n_sh};
						dsh_q   <= {d_mag, 17'd0};
						ovf_q   <= setup_ovf;
						neg_q   <= n_s[32] ^ d_s[32];
						quo_q   <= '0;
						cnt_q   <= 5'(QW - 1);
						bsel_q  <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_ge) begin
						rem_q <= div_diff;
					end
					quo_q <= {quo_q[QW-2:0], div_ge};
					dsh_q <= {1'b0, dsh_q[49:1]};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= S_TDONE;
					end
				end
				S_TDONE: begin
					if (!bsel_q) begin
						t1_q    <= t_sat;
						rem_q   <= {2'b00, n_sh};
						dsh_q   <= {d_mag, 17'd0};
						ovf_q   <= setup_ovf;
						neg_q   <= n_s[32] ^ d_s[32];
						quo_q   <= '0;
						cnt_q   <= 5'(QW - 1);
						bsel_q  <= 1'b1;
						state_q <= S_DIV;
					end else begin
						tmin_q <= nmin;
						tmax_q <= nmax;
						if (nmin > nmax) begin
							ov_q    <= 1'b0;
							state_q <= S_DECIDE;
						end else if (axis_q) begin
							ov_q    <= 1'b1;
							state_q <= S_DECIDE;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_AXIS;
						end
					end
				end
				S_DECIDE: begin
					if (!(hit && pend_valid_q && !out_free)) begin
						if (hit) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_idx_q   <= pend_idx_q;
								out_found_q <= 1'b1;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_idx_q   <= i_q[5:0];
							hits_q       <= hits_q + 7'd1;
						end
						i_q <= i_next;
						if (hit && hits_q == 7'(bvhq_pkg::MAX_HITS - 1)) begin
							state_q <= S_FIN;
						end else if (i_next < limit) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_idx_q    <= pend_valid_q ? pend_idx_q : 6'd0;
						out_found_q  <= pend_valid_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/bvhq_checker.sv -----
module bvhq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] leaf_index,
	input logic       found,
	input logic       last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(leaf_index) && $stable(found)
		&& $stable(last))
		else $error("result changed while stalled");

	// ack and no-hit results close the request
	a_nohit_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last)
		else $error("non-hit result without last");

	// ack and no-hit results carry index zero
	a_nohit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> leaf_index == 6'd0)
		else $error("non-hit result with nonzero index");

	// a taken request keeps the block busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a request");

endmodule

bind bvh_escape_index_overlap_query_core bvhq_checker u_bvhq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.leaf_index(leaf_index),
	.found     (found),
	.last      (last)
);

// ----- bench/tb_bvh_escape_index_overlap_query_core.sv -----
`timescale 1ns / 100ps

module tb_bvh_escape_index_overlap_query_core;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int STALL_LIMIT = 100000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [5:0] leaf_index;
		logic       found;
		logic       last;
	} hit_t;

	typedef struct {
		int                 count;
		logic [1:0]         mode;
		logic [5:0]         idx;
		logic signed [31:0] x0, z0, x1, z1;
		logic               leaf;
		logic [6:0]         skip;
		bit                 typed;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = '0;
	logic [5:0] node_index = '0;
	logic signed [31:0] coord_x0 = '0, coord_z0 = '0, coord_x1 = '0, coord_z1 = '0;
	logic is_leaf = 1'b0;
	logic [6:0] skip_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] leaf_index;
	logic found, last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;

	// tree mirror
	bvhq_pkg::node_t tree_mem [bvhq_pkg::NODES_DEF];
	int node_cnt;

	hit_t hit_q[$];
	int errors = 0;
	int tx_idle = 0, rx_idle = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_cnt = 0;
	row_t rows[$];

	bvh_escape_index_overlap_query_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .node_index(node_index),
		.coord_x0(coord_x0), .coord_z0(coord_z0),
		.coord_x1(coord_x1), .coord_z1(coord_z1),
		.is_leaf(is_leaf), .skip_count(skip_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.leaf_index(leaf_index), .found(found), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// append one expected result
	task automatic add_expect(hit_t h);
		hit_q.insert(hit_q.size(), h);
	endtask

	// append one stimulus row
	task automatic add_row(row_t r);
		rows.insert(rows.size(), r);
	endtask

	// q2.16 parameter of a slab bound, saturated
	function automatic longint t_param(longint num, longint den);
		longint t;
		t = (num * 65536) / den;
		if (t > 131071) t = 131071;
		if (t < -131072) t = -131072;
		return t;
	endfunction

	function automatic bit slab_pass(longint p, longint q, longint lo, longint hi,
			inout longint tmin, inout longint tmax);
		longint d, t1, t2, s;
		d = q - p;
		if (d == 0) return !(p < lo || p > hi);
		t1 = t_param(lo - p, d);
		t2 = t_param(hi - p, d);
		if (t1 > t2) begin
			s = t1; t1 = t2; t2 = s;
		end
		if (t1 > tmin) tmin = t1;
		if (t2 < tmax) tmax = t2;
		return tmin <= tmax;
	endfunction

	function automatic bit node_overlap(logic [1:0] m, longint x0, longint z0,
			longint x1, longint z1, int n);
		longint bx0, bz0, bx1, bz1, tmin, tmax;
		bx0 = tree_mem[n].min_x; bz0 = tree_mem[n].min_z;
		bx1 = tree_mem[n].max_x; bz1 = tree_mem[n].max_z;
		if (m == bvhq_pkg::MODE_RECT)
			return !(x0 > bx1 || x1 < bx0 || z0 > bz1 || z1 < bz0);
		tmin = 0; tmax = 65536;
		if (!slab_pass(x0, x1, bx0, bx1, tmin, tmax)) return 0;
		return slab_pass(z0, z1, bz0, bz1, tmin, tmax);
	endfunction

	// expected results of one accepted request
	task automatic predict_request(row_t r);
		int lim, i, hits;
		bit ov, lf;
		hit_t h;
		if (r.mode == bvhq_pkg::MODE_WRITE) begin
			tree_mem[r.idx] = '{r.x0, r.z0, r.x1, r.z1, r.leaf, r.skip};
		end
		if (r.mode == bvhq_pkg::MODE_WRITE || r.mode == MODE_NONE || r.typed) begin
			add_expect('{6'd0, 1'b0, 1'b1});
			return;
		end
		lim = node_cnt < bvhq_pkg::NODES_DEF ? node_cnt : bvhq_pkg::NODES_DEF;
		i = 0; hits = 0;
		while (i < lim && hits < bvhq_pkg::MAX_HITS) begin
			ov = node_overlap(r.mode, r.x0, r.z0, r.x1, r.z1, i);
			lf = tree_mem[i].leaf;
			if (ov && lf) begin
				add_expect('{i[5:0], 1'b1, 1'b0});
				hits++;
			end
			if (ov || lf) i++;
			else i += (tree_mem[i].skip == 0) ? 1 : tree_mem[i].skip;
		end
		if (hits == 0) add_expect('{6'd0, 1'b0, 1'b1});
		else begin
			h = hit_q.pop_back();
			h.last = 1'b1;
			add_expect(h);
		end
	endtask

	// offer one request, wait for acceptance
	task automatic send_request(row_t r);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode; node_index <= r.idx;
		coord_x0 <= r.x0; coord_z0 <= r.z0; coord_x1 <= r.x1; coord_z1 <= r.z1;
		is_leaf <= r.leaf; skip_count <= r.skip;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_request(r);
	endtask

	// node count update, only with the block idle
	task automatic set_count(int v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (hit_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[6:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		node_cnt = v;
	endtask

	function automatic logic signed [31:0] rand_coord(int spread);
		if ($urandom_range(19) == 0) return $urandom;
		return $signed($urandom_range(2 * spread)) - spread;
	endfunction

	function automatic row_t rand_node(int slot, bit all_leaf);
		row_t r;
		int c, hx, hz;
		r.count = -1; r.typed = 0; r.mode = bvhq_pkg::MODE_WRITE; r.idx = slot[5:0];
		c = rand_coord(32'h40000); hx = $urandom_range(32'h20000);
		r.x0 = c - hx; r.x1 = c + hx;
		c = rand_coord(32'h40000); hz = $urandom_range(32'h20000);
		r.z0 = c - hz; r.z1 = c + hz;
		if ($urandom_range(15) == 0) begin
			r.x0 = $urandom; r.z0 = $urandom; r.x1 = $urandom; r.z1 = $urandom;
		end
		r.leaf = all_leaf ? 1'b1 : 1'($urandom_range(1));
		r.skip = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(8));
		return r;
	endfunction

	function automatic row_t rand_request();
		row_t r;
		int k;
		k = $urandom_range(99);
		if (k < 30) return rand_node($urandom_range(63), 1'b0);
		r.count = -1; r.typed = 0;
		r.idx = 6'($urandom);
		r.leaf = 1'($urandom); r.skip = 7'($urandom);
		r.mode = (k < 36) ? MODE_NONE : (k < 68) ? bvhq_pkg::MODE_RECT : bvhq_pkg::MODE_SEG;
		r.x0 = rand_coord(32'h60000); r.z0 = rand_coord(32'h60000);
		r.x1 = rand_coord(32'h60000); r.z1 = rand_coord(32'h60000);
		if (r.mode == bvhq_pkg::MODE_RECT && $urandom_range(3) != 0) begin
			if (r.x0 > r.x1) {r.x0, r.x1} = {r.x1, r.x0};
			if (r.z0 > r.z1) {r.z0, r.z1} = {r.z1, r.z0};
		end
		if (r.mode == bvhq_pkg::MODE_SEG && $urandom_range(5) == 0) r.z1 = r.z0;
		if (r.mode == bvhq_pkg::MODE_SEG && $urandom_range(5) == 0) r.x1 = r.x0;
		return r;
	endfunction

	function automatic row_t mk(int cnt, logic [1:0] m, logic [5:0] ix,
			logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d,
			logic lf, logic [6:0] sk, bit ty);
		row_t r;
		r = '{cnt, m, ix, a, b, c, d, lf, sk, ty};
		return r;
	endfunction

	// receiver side with long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_req <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// result checker
	always @(posedge clk) begin
		hit_t e;
		if (out_valid && out_ready) begin
			if (hit_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result idx=%0d found=%0b last=%0b",
						leaf_index, found, last);
			end else begin
				e = hit_q.pop_front();
				if (leaf_index !== e.leaf_index || found !== e.found || last !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp idx=%0d found=%0b last=%0b got idx=%0d found=%0b last=%0b",
							e.leaf_index, e.found, e.last, leaf_index, found, last);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		node_cnt = 0;
		// directed rows
		add_row(mk(-1, bvhq_pkg::MODE_RECT, 6'd63, -32'sd4096, -32'sd4096, 32'sd4096, 32'sd4096, 0, 0, 1));
		add_row(mk(-1, MODE_NONE, 6'd63, 32'h7fffffff, 32'h80000000, 0, -1, 1, 7'd127, 1));
		add_row(mk(-1, bvhq_pkg::MODE_SEG, 6'd0, 0, 0, 32'sd4096, 32'sd4096, 0, 0, 1));
		add_row(mk(-1, bvhq_pkg::MODE_WRITE, 6'd0, -32'sd4096, -32'sd4096, 32'sd4096, 32'sd4096,
			0, 7'd3, 1));
		add_row(mk(-1, bvhq_pkg::MODE_WRITE, 6'd1, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 1, 7'd0, 1));
		add_row(mk(-1, bvhq_pkg::MODE_WRITE, 6'd2, 0, 0, 32'sd2048, 32'sd2048, 1, 7'd127, 1));
		add_row(mk(-1, bvhq_pkg::MODE_WRITE, 6'd3, 32'sh100000, 32'sh100000, 32'sh200000,
			32'sh200000, 0, 7'd0, 1));
		add_row(mk(-1, bvhq_pkg::MODE_WRITE, 6'd4, 32'sh100000, 32'sh100000, 32'sh200000,
			32'sh200000, 1, 7'd64, 1));
		add_row(mk(-1, bvhq_pkg::MODE_WRITE, 6'd5, -32'sh300000, -32'sh300000, -32'sh200000,
			-32'sh200000, 0, 7'd64, 1));
		add_row(mk(-1, bvhq_pkg::MODE_WRITE, 6'd63, 32'h80000000, 0, 32'h7fffffff, 0,
			1, 7'd127, 1));
		add_row(mk(6, bvhq_pkg::MODE_RECT, 6'd0, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 0, 0, 0));
		// miss the root: escape past its subtree, then skip zero on node 3
		add_row(mk(-1, bvhq_pkg::MODE_RECT, 6'd0, 32'sh50000, 32'sh50000, 32'sh60000,
			32'sh60000, 0, 0, 0));
		// touching edges overlap
		add_row(mk(-1, bvhq_pkg::MODE_RECT, 6'd0, 32'sd2048, 32'sd2048, 32'sh100000,
			32'sh100000, 0, 0, 0));
		add_row(mk(-1, bvhq_pkg::MODE_RECT, 6'd0, 32'sd100, 32'sd100, -32'sd100, -32'sd100,
			0, 0, 0));
		// parallel segments, inside and outside the slab
		add_row(mk(-1, bvhq_pkg::MODE_SEG, 6'd0, 32'sd1000, -32'sh200000, 32'sd1000,
			32'sh200000, 0, 0, 0));
		add_row(mk(-1, bvhq_pkg::MODE_SEG, 6'd0, 32'sh9000, -32'sh200000, 32'sh9000,
			32'sh200000, 0, 0, 0));
		add_row(mk(-1, bvhq_pkg::MODE_SEG, 6'd0, -32'sh10000, -32'sh10000, 32'sh180000,
			32'sh180000, 0, 0, 0));
		add_row(mk(-1, bvhq_pkg::MODE_SEG, 6'd0, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 0, 0, 0));
		add_row(mk(-1, bvhq_pkg::MODE_SEG, 6'd0, 32'sd500, 32'sd500, 32'sd500, 32'sd500,
			0, 0, 0));
		add_row(mk(-1, MODE_NONE, 6'd0, 0, 0, 0, 0, 0, 0, 1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 27; rx_idle = 62;
		foreach (rows[k]) begin
			if (rows[k].count >= 0) set_count(rows[k].count);
			send_request(rows[k]);
		end

		// full tree of leaves with random boxes
		for (int s = 0; s < bvhq_pkg::NODES_DEF; s++) send_request(rand_node(s, 1'b1));

		// every node a leaf and the query covers the plane: the hit cap ends the walk
		set_count(64);
		send_request(mk(-1, bvhq_pkg::MODE_RECT, 6'd0, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 0, 0, 0));

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle = 27; rx_idle = 62; n = 64;
				end
				1: begin
					tx_idle = 62; rx_idle = 27; n = 127;
				end
				default: begin
					tx_idle = 0; rx_idle = 0; n = $urandom_range(1, 64);
				end
			endcase
			set_count(n);
			if (p == 2) hold_req <= 1'b1;
			for (int k = 0; k < 8; k++) send_request(rand_request());
		end

		set_count(100);
		send_request(mk(-1, bvhq_pkg::MODE_SEG, 6'd0, -32'sd10, 5, 32'sd10, 5, 0, 0, 0));
		set_count(0);
		send_request(mk(-1, bvhq_pkg::MODE_RECT, 6'd0, 0, 0, 32'sd10, 32'sd10, 0, 0, 1));

		in_valid <= 1'b0;
		@(posedge clk);
		while (hit_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
